// File: rtl/core/pmq_pkg.sv
// pmq_pkg: shared types and constants for the PS/2 mouse packet queue.
// Used by pmq_front, pmq_cmd_fifo, pmq_back, the top level and the checker.
// No dependencies.
package pmq_pkg;

	// Default ring size; the ring holds at most RING_DEPTH-1 packets
	localparam int RING_DEPTH_DEF = 64;

	// Depth of the command queue between the front and back parts
	localparam int CMD_FIFO_DEPTH = 4;

	// Stream widths
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 24;

	// Operation codes carried on s_tuser
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_READ = 1'b1;

	// packet_mode register values (3 acts as standard)
	localparam logic [1:0] MODE_STD   = 2'd0;
	localparam logic [1:0] MODE_WHEEL = 2'd1;
	localparam logic [1:0] MODE_EXTRA = 2'd2;

	// One queued packet, move_x in the lowest bits
	typedef struct packed {
		logic       scroll_down;
		logic       scroll_up;
		logic [2:0] button_bits;
		logic [8:0] move_y;
		logic [8:0] move_x;
	} pkt_entry_t;

	// Command passed from front to back: store a packet or pop the oldest one
	typedef struct packed {
		logic       is_read;
		pkt_entry_t entry;
	} cmd_t;

endpackage

// File: rtl/core/pmq_front.sv
// pmq_front: accepts stream requests, assembles mouse bytes into packets and
// issues store and pop commands. Holds the packet_mode register.
// Depends on pmq_pkg.
module pmq_front
	import pmq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [1:0]           cfg_wr_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	input  logic                 q_full,
	output logic                 q_push,
	output cmd_t                 q_cmd
);

	typedef enum logic [3:0] {
		PH_HDR = 4'b0001,
		PH_X   = 4'b0010,
		PH_Y   = 4'b0100,
		PH_EXT = 4'b1000
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [1:0] mode_q;
	logic [7:0] hdr_q, x_q, y_q;
	logic       accept, is_byte, four_byte, complete;
	logic [7:0] y_now;
	pkt_entry_t entry;

	// Sign-extend a movement byte; a zero byte stays zero
	function automatic logic [8:0] movement(input logic [7:0] mag, input logic neg);
		movement = {neg && (mag != 8'd0), mag};
	endfunction

	assign s_tready  = !q_full;
	assign accept    = s_tvalid && s_tready;
	assign is_byte   = (s_tuser == OP_BYTE);
	assign four_byte = (mode_q == MODE_WHEEL) || (mode_q == MODE_EXTRA);
	assign complete  = is_byte && (((phase_q == PH_Y) && !four_byte) || (phase_q == PH_EXT));
	assign y_now     = (phase_q == PH_Y) ? s_tdata : y_q;

	// Packet decode at completion
	always_comb begin
		entry.move_x      = movement(x_q, hdr_q[4]);
		entry.move_y      = movement(y_now, hdr_q[5]);
		if (hdr_q[6] || hdr_q[7]) begin
			entry.move_x = '0;
			entry.move_y = '0;
		end
		entry.button_bits = hdr_q[2:0];
		entry.scroll_up   = (mode_q == MODE_WHEEL) && (phase_q == PH_EXT) && s_tdata[7];
		entry.scroll_down = (mode_q == MODE_WHEEL) && (phase_q == PH_EXT) &&
		                    !s_tdata[7] && (s_tdata != 8'd0);
	end

	// Command out: reads always, bytes only when they finish a packet
	assign q_push        = accept && (!is_byte || complete);
	assign q_cmd.is_read = !is_byte;
	assign q_cmd.entry   = entry;

	// Byte phase sequencing
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_HDR: begin
				if (s_tdata[3]) phase_d = PH_X;
			end
			PH_X: phase_d = PH_Y;
			PH_Y: begin
				phase_d = four_byte ? PH_EXT : PH_HDR;
			end
			PH_EXT: phase_d = PH_HDR;
			default: phase_d = PH_HDR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			mode_q  <= MODE_STD;
		end else begin
			if (cfg_wr_en) mode_q <= cfg_wr_data;
			if (accept && is_byte) phase_q <= phase_d;
		end
	end

	// Byte capture
	always_ff @(posedge clk) begin
		if (accept && is_byte) begin
			if (phase_q == PH_HDR) hdr_q <= s_tdata;
			if (phase_q == PH_X)   x_q   <= s_tdata;
			if (phase_q == PH_Y)   y_q   <= s_tdata;
		end
	end

endmodule

// File: rtl/core/pmq_cmd_fifo.sv
// pmq_cmd_fifo: short command queue decoupling the front and back parts.
// Registered storage, first-word-fall-through head.
// Depends on pmq_pkg.
module pmq_cmd_fifo
	import pmq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic empty,
	output logic full
);

	localparam int PW = $clog2(CMD_FIFO_DEPTH);

	cmd_t          slot_q [CMD_FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (PW+1)'(CMD_FIFO_DEPTH));
	assign head  = slot_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// File: rtl/core/pmq_back.sv
// pmq_back: packet ring memory with overwrite-oldest policy, pop handling and
// the output register stage. Depends on pmq_pkg.
module pmq_back
	import pmq_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  cmd_t                  q_head,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tuser
);

	localparam int PW = $clog2(RING_DEPTH);

	pkt_entry_t    ring_mem [RING_DEPTH];
	logic [PW-1:0] wp_q, rp_q, wp_nxt, rp_nxt;
	logic          wr_en, rd_en, ring_empty;
	logic          s1_valid_q, s1_hit_q, s1_ready, s1_move;
	pkt_entry_t    rdata_s1;
	logic          out_valid_q, out_hit_q;
	pkt_entry_t    out_data_q;

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		ring_next = (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wp_nxt     = ring_next(wp_q);
	assign rp_nxt     = ring_next(rp_q);
	assign ring_empty = (wp_q == rp_q);

	// Output side handshake
	assign s1_move  = s1_valid_q && (!out_valid_q || m_tready);
	assign s1_ready = !s1_valid_q || s1_move;

	// Command issue: stores always go, pops wait for room in stage 1
	assign q_pop = !q_empty && (!q_head.is_read || s1_ready);
	assign wr_en = q_pop && !q_head.is_read;
	assign rd_en = q_pop && q_head.is_read && !ring_empty;

	// Ring pointers; a store into a full ring drops the oldest entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= wp_nxt;
				if (wp_nxt == rp_q) rp_q <= rp_nxt;
			end else if (rd_en) begin
				rp_q <= rp_nxt;
			end
		end
	end

	// Ring memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) ring_mem[wp_q] <= q_head.entry;
		if (rd_en) rdata_s1 <= ring_mem[rp_q];
	end

	// Stage 1 and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s1_hit_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_hit_q   <= 1'b0;
		end else begin
			if (s1_ready) begin
				s1_valid_q <= q_pop && q_head.is_read;
				s1_hit_q   <= rd_en;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
				out_hit_q   <= s1_hit_q;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) out_data_q <= s1_hit_q ? rdata_s1 : '0;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_hit_q;
	assign m_tdata  = {(OUT_DATA_W - $bits(pkt_entry_t))'(0), out_data_q};

endmodule

// File: rtl/core/ps2_mouse_packet_queue.sv
// ps2_mouse_packet_queue: top level of the PS/2 mouse packet queue.
// Instantiates pmq_front, pmq_cmd_fifo and pmq_back; depends on pmq_pkg.
//
// Usage:
//   The slave stream takes requests: s_tuser selects a received mouse byte
//   (OP_BYTE, byte on s_tdata[7:0]) or a read of the oldest packet (OP_READ).
//   Bytes are assembled into 3-byte packets, or 4-byte packets when
//   packet_mode selects wheel or extra-button mode; headers without bit 3
//   are dropped to resynchronize. Each finished packet is stored in a ring of
//   RING_DEPTH entries; a store into a full ring drops the oldest packet.
//   Each read returns one item on the master stream: m_tuser is 1 with the
//   packet on m_tdata, or 0 with all-zero data if the ring was empty.
//   packet_mode is written through cfg_wr_en / cfg_wr_data while idle.
// Timing:
//   One request per cycle while s_tready is high. A read is queued at the
//   accept edge, then its result passes the registered ring read and the
//   output register.
// Reset:
//   arst_n clears the byte assembler, mode, pointers and queues; the ring is
//   not cleared. If the master side stalls, results back up in the output
//   register and the command queue, and s_tready drops when the queue fills.
module ps2_mouse_packet_queue
	import pmq_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [1:0]            cfg_wr_data,  // packet_mode
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,      // [7:0] data_byte
	input  logic                  s_tuser,      // [0] operation
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,      // [8:0] move_x, [17:9] move_y,
	                                            // [20:18] button_bits, [21] scroll_up,
	                                            // [22] scroll_down, [23] zero
	output logic                  m_tuser       // [0] packet_valid
);

	logic q_push, q_pop, q_empty, q_full;
	cmd_t q_cmd, q_head;

	pmq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_cmd)
	);

	pmq_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(q_cmd),
		.pop     (q_pop),
		.head    (q_head),
		.empty   (q_empty),
		.full    (q_full)
	);

	pmq_back #(
		.RING_DEPTH(RING_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

// File: rtl/core/pmq_checker.sv
// pmq_checker: port-level checks for ps2_mouse_packet_queue, bound to it.
// Depends on pmq_pkg.
module pmq_checker
	import pmq_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tuser
);

	// A stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// An empty-ring read carries all-zero data
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("empty read with nonzero data");

	// Scroll up and down are exclusive
	a_scroll_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[21] && m_tdata[22]))
		else $error("both scroll bits set");

	// A negative zero movement cannot occur
	a_no_neg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[8:0] != 9'h100) && (m_tdata[17:9] != 9'h100))
		else $error("movement encoded as negative zero");

endmodule

bind ps2_mouse_packet_queue pmq_checker u_pmq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
